// ----- hdl/fee_pkg.sv -----
package fee_pkg;

    // Command codes of the input channel
    localparam logic [2:0] CMD_READ       = 3'd0;
    localparam logic [2:0] CMD_WRITE_WORD = 3'd1;
    localparam logic [2:0] CMD_WRITE_BYTE = 3'd2;
    localparam logic [2:0] CMD_FLUSH      = 3'd3;
    localparam logic [2:0] CMD_MOUNT      = 3'd4;

    // Status codes of the result channel
    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_IMAGE     = 2'd1;
    localparam logic [1:0] STAT_CORRUPT   = 2'd2;
    localparam logic [1:0] STAT_UNMOUNTED = 2'd3;

    localparam logic [31:0] ERASED_WORD   = 32'hFFFF_FFFF;
    localparam logic [7:0]  UNUSED_INDEX  = 8'hFF;
    localparam logic [31:0] INDEX_FILL    = 32'hFFFF_FF00;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISP,
        ST_WR_CMP,
        ST_M_ZERO,
        ST_M_R0,
        ST_M_R1,
        ST_M_R2,
        ST_M_R3,
        ST_M_R4,
        ST_M_SEL,
        ST_IMG_ERASE,
        ST_IMG_VER,
        ST_IMG_DATA,
        ST_IMG_RDY,
        ST_RP_B0,
        ST_RP_BASE,
        ST_RP_HISS,
        ST_RP_HDR,
        ST_RP_IDX,
        ST_RP_VAL,
        ST_FL_CNT,
        ST_FL_CHK,
        ST_FL_SCAN,
        ST_FL_SLOT,
        ST_FL_RMW,
        ST_FL_VAL,
        ST_FL_END,
        ST_FIN,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        state_t op;
        logic   latch;
        logic   load_out;
    } ctrl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       mounted;
        logic       idx_ok;
        logic       cnt_last;
        logic       clr_last;
        logic       erase_last;
        logic       fresh;
        logic       p_end;
        logic       w_erased;
        logic       idx_ff;
        logic       idx_bad;
        logic       k_last;
        logic       dirty_any;
        logic       dirty_bit;
        logic       no_room;
        logic       slot_nz;
        logic       out_free;
    } stat_t;

endpackage

// ----- hdl/flash_eeprom_emulation_log.sv -----
// Two-bank flash EEPROM emulation: a NUM_SLOTS-word shadow store backed by a log in
// an internal flash of two banks of BANK_WORDS words. Every command returns exactly one
// result. After reset the flash is swept to erased and the shadow to zero, one word per
// cycle, before the first command is taken. All flash traffic goes through one flash
// array with one write port and one read port, each taking one word per cycle. Mount
// on fresh flash and a flush whose dirty words do not fit in the log write a new bank
// image. A new command is taken as soon as the previous result sits in the output register.
module flash_eeprom_emulation_log
    import fee_pkg::*;
#(
    parameter int NUM_SLOTS  = 64,
    parameter int BANK_WORDS = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_cmd,
    input  logic [5:0]         s_word_index,
    input  logic [1:0]         s_byte_lane,
    input  logic [31:0]        s_wdata,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_read_data,
    output logic [1:0]         m_status,
    output logic               m_active_bank,
    output logic signed [31:0] m_bank_version,
    output logic [14:0]        m_free_offset
);

    ctrl_t ctrl;
    stat_t stat;

    fee_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    fee_dp #(
        .NUM_SLOTS  (NUM_SLOTS),
        .BANK_WORDS (BANK_WORDS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .stat           (stat),
        .s_cmd          (s_cmd),
        .s_word_index   (s_word_index),
        .s_byte_lane    (s_byte_lane),
        .s_wdata        (s_wdata),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_status       (m_status),
        .m_active_bank  (m_active_bank),
        .m_bank_version (m_bank_version),
        .m_free_offset  (m_free_offset)
    );

endmodule

// ----- hdl/fee_ram.sv -----
module fee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/fee_ctrl.sv -----
module fee_ctrl
    import fee_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output ctrl_t ctrl
);

    state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance the sequence
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:     if (stat.clr_last) state_next = ST_IDLE;
            ST_IDLE:      if (s_valid) state_next = ST_DISP;
            ST_DISP: begin
                if (stat.cmd == CMD_MOUNT) begin
                    state_next = ST_M_ZERO;
                end else if (stat.cmd inside {[CMD_READ:CMD_FLUSH]} && !stat.mounted) begin
                    state_next = ST_FIN;
                end else if (stat.cmd inside {CMD_WRITE_WORD, CMD_WRITE_BYTE}) begin
                    state_next = stat.idx_ok ? ST_WR_CMP : ST_FIN;
                end else if (stat.cmd == CMD_FLUSH) begin
                    state_next = stat.dirty_any ? ST_FL_CNT : ST_FIN;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_WR_CMP:    state_next = ST_FIN;
            ST_M_ZERO:    if (stat.cnt_last) state_next = ST_M_R0;
            ST_M_R0:      state_next = ST_M_R1;
            ST_M_R1:      state_next = ST_M_R2;
            ST_M_R2:      state_next = ST_M_R3;
            ST_M_R3:      state_next = ST_M_R4;
            ST_M_R4:      state_next = ST_M_SEL;
            ST_M_SEL:     state_next = stat.fresh ? ST_IMG_ERASE : ST_RP_B0;
            ST_IMG_ERASE: if (stat.erase_last) state_next = ST_IMG_VER;
            ST_IMG_VER:   state_next = ST_IMG_DATA;
            ST_IMG_DATA:  if (stat.cnt_last) state_next = ST_IMG_RDY;
            ST_IMG_RDY:   state_next = ST_FIN;
            ST_RP_B0:     state_next = ST_RP_BASE;
            ST_RP_BASE:   if (stat.cnt_last) state_next = ST_RP_HISS;
            ST_RP_HISS:   state_next = stat.p_end ? ST_FIN : ST_RP_HDR;
            ST_RP_HDR:    state_next = stat.w_erased ? ST_FIN : ST_RP_IDX;
            ST_RP_IDX: begin
                if (stat.idx_ff || stat.idx_bad || stat.p_end) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_RP_VAL;
                end
            end
            ST_RP_VAL:    state_next = stat.k_last ? ST_RP_HISS : ST_RP_IDX;
            ST_FL_CNT:    if (stat.cnt_last) state_next = ST_FL_CHK;
            ST_FL_CHK:    state_next = stat.no_room ? ST_IMG_ERASE : ST_FL_SCAN;
            ST_FL_SCAN: begin
                if (stat.dirty_bit) begin
                    state_next = ST_FL_SLOT;
                end else if (stat.cnt_last) begin
                    state_next = ST_FL_END;
                end
            end
            ST_FL_SLOT:   state_next = stat.slot_nz ? ST_FL_RMW : ST_FL_VAL;
            ST_FL_RMW:    state_next = ST_FL_VAL;
            ST_FL_VAL:    state_next = stat.cnt_last ? ST_FL_END : ST_FL_SCAN;
            ST_FL_END:    state_next = ST_FIN;
            ST_FIN:       state_next = ST_RESP;
            ST_RESP:      if (stat.out_free) state_next = ST_IDLE;
            default:      state_next = ST_CLEAR;
        endcase
    end

    // Drive commands
    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        ctrl.op       = state_reg;
        ctrl.latch    = (state_reg == ST_IDLE) && s_valid;
        ctrl.load_out = (state_reg == ST_RESP) && stat.out_free;
    end

endmodule

// ----- hdl/fee_dp.sv -----
module fee_dp
    import fee_pkg::*;
#(
    parameter int NUM_SLOTS  = 64,
    parameter int BANK_WORDS = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctrl_t              ctrl,
    output stat_t              stat,
    input  logic [2:0]         s_cmd,
    input  logic [5:0]         s_word_index,
    input  logic [1:0]         s_byte_lane,
    input  logic [31:0]        s_wdata,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_read_data,
    output logic [1:0]         m_status,
    output logic               m_active_bank,
    output logic signed [31:0] m_bank_version,
    output logic [14:0]        m_free_offset
);

    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
    localparam int FA_W       = $clog2(2 * BANK_WORDS);
    localparam int PW         = $clog2(2 * BANK_WORDS + 1);
    localparam int OW         = $clog2(4 * BANK_WORDS + 1);
    localparam int READY_WORD = NUM_SLOTS + 1;
    localparam int LOG_START  = NUM_SLOTS + 2;
    localparam int BANK_BYTES = 4 * BANK_WORDS;

    logic [2:0]           cmd_reg;
    logic [5:0]           idx_reg;
    logic [1:0]           lane_reg;
    logic [31:0]          wdata_reg;
    logic [PW-1:0]        ptr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [1:0]           k_reg;
    logic [31:0]          w_reg;
    logic [31:0]          val_reg;
    logic                 rdy_reg;
    logic [31:0]          v0_reg;
    logic [31:0]          v1_reg;
    logic                 bank_reg;
    logic [31:0]          ver_reg;
    logic [OW-1:0]        app_reg;
    logic                 mounted_reg;
    logic [NUM_SLOTS-1:0] dirty_reg;
    logic [1:0]           status_reg;

    logic              fl_we_req, fl_we, fl_rbank;
    logic [31:0]       fl_wrel, fl_rrel, fl_wdata, fl_rdata;
    logic [FA_W-1:0]   fl_waddr, fl_raddr;
    logic              sh_we;
    logic [SLOT_W-1:0] sh_waddr, sh_raddr;
    logic [31:0]       sh_wdata, sh_rdata;

    logic [31:0]       app32, a_word, iw, off32, extra, need;
    logic [1:0]        slot;
    logic [4:0]        slot_sh, lane_sh;
    logic [7:0]        byte_sel;
    logic [31:0]       new_val;
    logic              sel1;
    logic [SLOT_W-1:0] idx_s, cnt_s, byte_s;

    fee_ram #(.WIDTH(32), .DEPTH(2 * BANK_WORDS)) u_flash (
        .aclk  (aclk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .raddr (fl_raddr),
        .rdata (fl_rdata)
    );

    fee_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_shadow (
        .aclk  (aclk),
        .we    (sh_we),
        .waddr (sh_waddr),
        .wdata (sh_wdata),
        .raddr (sh_raddr),
        .rdata (sh_rdata)
    );

    // Decode log and flush positions
    always_comb begin
        idx_s    = SLOT_W'(idx_reg);
        cnt_s    = cnt_reg[SLOT_W-1:0];
        app32    = 32'(app_reg);
        slot     = app_reg[1:0];
        slot_sh  = {slot, 3'b000};
        lane_sh  = {lane_reg, 3'b000};
        a_word   = app32 >> 2;
        iw       = a_word - 32'(slot) - 32'd1;
        byte_sel = w_reg[{k_reg, 3'b000} +: 8];
        byte_s   = SLOT_W'(byte_sel);
        off32    = app32 & ~32'd3;
        extra    = (slot != 2'd0) ? 32'd4 - 32'(slot) : 32'd0;
        need     = 32'(count_reg) + ((32'(count_reg) + 32'd3 - extra) >> 2);
        if (cmd_reg == CMD_WRITE_WORD) begin
            new_val = wdata_reg;
        end else begin
            new_val = (sh_rdata & ~(32'h0000_00FF << lane_sh))
                    | ({24'd0, wdata_reg[7:0]} << lane_sh);
        end
        if (v1_reg == ERASED_WORD) begin
            sel1 = 1'b0;
        end else if (v0_reg == ERASED_WORD) begin
            sel1 = 1'b1;
        end else begin
            sel1 = $signed(v1_reg) > $signed(v0_reg);
        end
    end

    // Report status to the controller
    always_comb begin
        stat.cmd        = cmd_reg;
        stat.mounted    = mounted_reg;
        stat.idx_ok     = 32'(idx_reg) < NUM_SLOTS;
        stat.cnt_last   = 32'(cnt_reg) == NUM_SLOTS - 1;
        stat.clr_last   = 32'(ptr_reg) == 2 * BANK_WORDS - 1;
        stat.erase_last = 32'(ptr_reg) == BANK_WORDS - 1;
        stat.fresh      = (v0_reg == ERASED_WORD) && (v1_reg == ERASED_WORD);
        stat.p_end      = 32'(ptr_reg) >= BANK_WORDS;
        stat.w_erased   = fl_rdata == ERASED_WORD;
        stat.idx_ff     = byte_sel == UNUSED_INDEX;
        stat.idx_bad    = 32'(byte_sel) >= NUM_SLOTS;
        stat.k_last     = k_reg == 2'd3;
        stat.dirty_any  = |dirty_reg;
        stat.dirty_bit  = dirty_reg[cnt_s];
        stat.no_room    = off32 + (need << 2) >= 32'(BANK_BYTES);
        stat.slot_nz    = slot != 2'd0;
        stat.out_free   = !m_valid || m_ready;
    end

    // Steer the flash port
    always_comb begin
        fl_we_req = 1'b0;
        fl_wrel   = 32'd0;
        fl_wdata  = ERASED_WORD;
        fl_rrel   = 32'd0;
        fl_rbank  = bank_reg;
        case (ctrl.op)
            ST_CLEAR:     fl_we_req = 1'b1;
            ST_M_R0: begin
                fl_rrel  = 32'(READY_WORD);
                fl_rbank = 1'b0;
            end
            ST_M_R1:      fl_rbank = 1'b0;
            ST_M_R2: begin
                fl_rrel  = 32'(READY_WORD);
                fl_rbank = 1'b1;
            end
            ST_M_R3:      fl_rbank = 1'b1;
            ST_IMG_ERASE: begin
                fl_we_req = 1'b1;
                fl_wrel   = 32'(ptr_reg);
            end
            ST_IMG_VER: begin
                fl_we_req = 1'b1;
                fl_wdata  = ver_reg;
            end
            ST_IMG_DATA: begin
                fl_we_req = 1'b1;
                fl_wrel   = 32'(cnt_reg) + 32'd1;
                fl_wdata  = sh_rdata;
            end
            ST_IMG_RDY: begin
                fl_we_req = 1'b1;
                fl_wrel   = 32'(READY_WORD);
                fl_wdata  = 32'd0;
            end
            ST_RP_B0:     fl_rrel = 32'd1;
            ST_RP_BASE:   fl_rrel = 32'(cnt_reg) + 32'd2;
            ST_RP_HISS:   fl_rrel = 32'(ptr_reg);
            ST_RP_IDX:    fl_rrel = 32'(ptr_reg);
            ST_FL_SLOT: begin
                fl_rrel   = iw;
                fl_we_req = !stat.slot_nz;
                fl_wrel   = a_word;
                fl_wdata  = INDEX_FILL | 32'(cnt_reg);
            end
            ST_FL_RMW: begin
                fl_we_req = 1'b1;
                fl_wrel   = iw;
                fl_wdata  = (fl_rdata & ~(32'h0000_00FF << slot_sh))
                          | (32'(cnt_reg) << slot_sh);
            end
            ST_FL_VAL: begin
                fl_we_req = 1'b1;
                fl_wrel   = stat.slot_nz ? a_word : a_word + 32'd1;
                fl_wdata  = val_reg;
            end
            default: ;
        endcase
        if (ctrl.op == ST_CLEAR) begin
            fl_we    = 1'b1;
            fl_waddr = FA_W'(ptr_reg);
        end else begin
            fl_we    = fl_we_req && (fl_wrel < 32'(BANK_WORDS));
            fl_waddr = FA_W'(fl_wrel + (bank_reg ? 32'(BANK_WORDS) : 32'd0));
        end
        fl_raddr = FA_W'(fl_rrel + (fl_rbank ? 32'(BANK_WORDS) : 32'd0));
    end

    // Steer the shadow port
    always_comb begin
        sh_we    = 1'b0;
        sh_waddr = cnt_s;
        sh_wdata = 32'd0;
        sh_raddr = idx_s;
        case (ctrl.op)
            ST_CLEAR: begin
                sh_we    = 32'(ptr_reg) < NUM_SLOTS;
                sh_waddr = SLOT_W'(ptr_reg);
            end
            ST_WR_CMP: begin
                sh_we    = new_val != sh_rdata;
                sh_waddr = idx_s;
                sh_wdata = new_val;
            end
            ST_M_ZERO:    sh_we = 1'b1;
            ST_IMG_VER:   sh_raddr = '0;
            ST_IMG_DATA:  sh_raddr = SLOT_W'(cnt_reg + CNT_W'(1));
            ST_RP_BASE: begin
                sh_we    = 1'b1;
                sh_wdata = fl_rdata;
            end
            ST_RP_VAL: begin
                sh_we    = 1'b1;
                sh_waddr = byte_s;
                sh_wdata = fl_rdata;
            end
            ST_FL_SCAN:   sh_raddr = cnt_s;
            default: ;
        endcase
    end

    // Capture the input transaction
    always_ff @(posedge aclk) begin
        if (ctrl.latch) begin
            cmd_reg   <= s_cmd;
            idx_reg   <= s_word_index;
            lane_reg  <= s_byte_lane;
            wdata_reg <= s_wdata;
        end
    end

    // Working registers of the sequences
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            ST_M_R1:    rdy_reg <= fl_rdata == 32'd0;
            ST_M_R2:    v0_reg  <= rdy_reg ? fl_rdata : ERASED_WORD;
            ST_M_R3:    rdy_reg <= fl_rdata == 32'd0;
            ST_M_R4:    v1_reg  <= rdy_reg ? fl_rdata : ERASED_WORD;
            ST_RP_HDR:  w_reg   <= fl_rdata;
            ST_FL_SLOT: val_reg <= sh_rdata;
            default: ;
        endcase
    end

    // Update the persistent state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            cnt_reg     <= '0;
            count_reg   <= '0;
            k_reg       <= '0;
            bank_reg    <= 1'b0;
            ver_reg     <= 32'd0;
            app_reg     <= '0;
            mounted_reg <= 1'b0;
            dirty_reg   <= '0;
            status_reg  <= STAT_DONE;
        end else begin
            case (ctrl.op)
                ST_CLEAR:     ptr_reg <= ptr_reg + PW'(1);
                ST_DISP: begin
                    cnt_reg   <= '0;
                    count_reg <= '0;
                    if (cmd_reg inside {[CMD_READ:CMD_FLUSH]} && !mounted_reg) begin
                        status_reg <= STAT_UNMOUNTED;
                    end else begin
                        status_reg <= STAT_DONE;
                    end
                end
                ST_WR_CMP: begin
                    if (new_val != sh_rdata) dirty_reg[idx_s] <= 1'b1;
                end
                ST_M_ZERO: begin
                    cnt_reg     <= cnt_reg + CNT_W'(1);
                    dirty_reg   <= '0;
                    mounted_reg <= 1'b1;
                end
                ST_M_SEL: begin
                    cnt_reg <= '0;
                    ptr_reg <= '0;
                    if (stat.fresh) begin
                        ver_reg    <= 32'd0;
                        bank_reg   <= 1'b0;
                        status_reg <= STAT_IMAGE;
                    end else begin
                        bank_reg <= sel1;
                        ver_reg  <= sel1 ? v1_reg : v0_reg;
                    end
                end
                ST_IMG_ERASE: ptr_reg <= ptr_reg + PW'(1);
                ST_IMG_VER:   cnt_reg <= '0;
                ST_IMG_DATA:  cnt_reg <= cnt_reg + CNT_W'(1);
                ST_IMG_RDY: begin
                    dirty_reg  <= '0;
                    app_reg    <= OW'(LOG_START * 4);
                    status_reg <= STAT_IMAGE;
                end
                ST_RP_B0:     cnt_reg <= '0;
                ST_RP_BASE: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    ptr_reg <= PW'(LOG_START);
                end
                ST_RP_HISS: begin
                    if (stat.p_end) app_reg <= OW'(BANK_BYTES);
                end
                ST_RP_HDR: begin
                    if (stat.w_erased) begin
                        app_reg <= OW'({ptr_reg, 2'b00});
                    end else begin
                        ptr_reg <= ptr_reg + PW'(1);
                        k_reg   <= 2'd0;
                    end
                end
                ST_RP_IDX: begin
                    if (stat.idx_ff) begin
                        app_reg <= OW'({ptr_reg, k_reg});
                    end else if (stat.idx_bad) begin
                        app_reg    <= OW'(BANK_BYTES);
                        status_reg <= STAT_CORRUPT;
                    end else if (stat.p_end) begin
                        app_reg <= OW'(BANK_BYTES);
                    end
                end
                ST_RP_VAL: begin
                    ptr_reg <= ptr_reg + PW'(1);
                    k_reg   <= k_reg + 2'd1;
                end
                ST_FL_CNT: begin
                    count_reg <= count_reg + CNT_W'(stat.dirty_bit);
                    cnt_reg   <= cnt_reg + CNT_W'(1);
                end
                ST_FL_CHK: begin
                    cnt_reg <= '0;
                    ptr_reg <= '0;
                    if (stat.no_room) begin
                        ver_reg    <= ver_reg + 32'd1;
                        bank_reg   <= !bank_reg;
                        status_reg <= STAT_IMAGE;
                    end
                end
                ST_FL_SCAN: begin
                    if (!stat.dirty_bit) cnt_reg <= cnt_reg + CNT_W'(1);
                end
                ST_FL_VAL: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (slot == 2'd3) begin
                        app_reg <= app_reg + OW'(1);
                    end else if (slot != 2'd0) begin
                        app_reg <= app_reg + OW'(5);
                    end else begin
                        app_reg <= app_reg + OW'(9);
                    end
                end
                ST_FL_END:    dirty_reg <= '0;
                default: ;
            endcase
        end
    end

    // Hold the result until the transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (ctrl.load_out) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            m_read_data    <= stat.idx_ok ? sh_rdata : 32'd0;
            m_status       <= status_reg;
            m_active_bank  <= bank_reg;
            m_bank_version <= ver_reg;
            m_free_offset  <= app32[14:0];
        end
    end

    a_flush_clears_dirty: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == ST_FL_END) |=> (dirty_reg == '0))
        else $error("dirty words left after flush");

    a_image_sets_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == ST_IMG_RDY) |=> (app_reg == OW'(LOG_START * 4)) && (status_reg == STAT_IMAGE))
        else $error("image write left wrong append offset or status");

    a_mount_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(mounted_reg))
        else $error("mounted flag dropped");

    a_result_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.load_out && (cmd_reg == CMD_READ) && mounted_reg) |=> (m_status == STAT_DONE))
        else $error("read returned a non-done status");

endmodule
